// ===== rtl/rdu_pkg.sv =====
package rdu_pkg;

  // wide signed working width for exact products and sums
  localparam int XW = 68;

  typedef logic signed [XW-1:0] wide_t;
  typedef logic signed [31:0] q_t;
  // three Q4.28 components, x in the lowest bits
  typedef logic [2:0][31:0] vec_t;

  // clamp to the 32-bit signed range
  function automatic q_t sat32(input wide_t v);
    q_t res;
    if (v > wide_t'(64'sh7fffffff)) begin
      res = 32'sh7fffffff;
    end else if (v < -wide_t'(64'sh80000000)) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // round to nearest, ties up, dropping f fraction bits
  function automatic wide_t rnd(input wide_t p, input int unsigned f);
    wide_t half;
    half = wide_t'(1) <<< (f - 1);
    return (p + half) >>> f;
  endfunction

endpackage

// ===== rtl/rdu_dot.sv =====
module rdu_dot import rdu_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  vec_t        dir,
  input  vec_t        nrm,
  input  logic [30:0] eta,
  output logic        out_valid,
  output q_t          cosine,
  output vec_t        out_dir,
  output vec_t        out_nrm,
  output logic [30:0] out_eta
);

  localparam wide_t ONE = wide_t'(1) <<< FRAC_BITS;

  logic        a_valid;
  wide_t       a_negp [3];
  vec_t        a_dir;
  vec_t        a_nrm;
  logic [30:0] a_eta;
  wide_t       dot;

  // stage A: negated products of dir and normal
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_negp[i] <= -(wide_t'($signed(dir[i])) * wide_t'($signed(nrm[i])));
      end
      a_dir <= dir;
      a_nrm <= nrm;
      a_eta <= eta;
    end
  end

  // stage B: rounded sum, capped at one
  assign dot = rnd(a_negp[0], FRAC_BITS) + rnd(a_negp[1], FRAC_BITS)
             + rnd(a_negp[2], FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cosine  <= sat32((dot < ONE) ? dot : ONE);
      out_dir <= a_dir;
      out_nrm <= a_nrm;
      out_eta <= a_eta;
    end
  end

endmodule

// ===== rtl/rdu_perp.sv =====
module rdu_perp import rdu_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  q_t          cosine,
  input  vec_t        dir,
  input  vec_t        nrm,
  input  logic [30:0] eta,
  output logic        out_valid,
  output vec_t        perp,
  output vec_t        out_nrm,
  output logic [31:0] mag
);

  localparam wide_t ONE = wide_t'(1) <<< FRAC_BITS;
  localparam wide_t MAG_MAX = wide_t'(64'hffffffff);

  logic [5:0]  v;
  wide_t       c_prod [3];
  vec_t        c_dir, d_t, f_perp, g_perp;
  vec_t        c_nrm, d_nrm, e_nrm, f_nrm, g_nrm;
  logic [30:0] c_eta, d_eta;
  wide_t       e_prod [3];
  wide_t       g_sq [3];
  wide_t       len, diff, absd;

  // valid bits for stages C..H
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_valid};
    end
  end

  assign out_valid = v[5];

  assign len  = rnd(g_sq[0], FRAC_BITS) + rnd(g_sq[1], FRAC_BITS)
              + rnd(g_sq[2], FRAC_BITS);
  assign diff = ONE - len;
  assign absd = (diff < 0) ? -diff : diff;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // C: cosine times normal
        c_prod[i] <= wide_t'($signed(cosine)) * wide_t'($signed(nrm[i]));
        // D: t = dir + cosine*n
        d_t[i] <= sat32(wide_t'($signed(c_dir[i])) + rnd(c_prod[i], FRAC_BITS));
        // E: eta * t
        e_prod[i] <= wide_t'($signed({1'b0, d_eta})) * wide_t'($signed(d_t[i]));
        // F: perpendicular part
        f_perp[i] <= sat32(rnd(e_prod[i], FRAC_BITS));
        // G: squares
        g_sq[i] <= wide_t'($signed(f_perp[i])) * wide_t'($signed(f_perp[i]));
      end
      c_dir <= dir;
      c_nrm <= nrm;
      c_eta <= eta;
      d_nrm <= c_nrm;
      d_eta <= c_eta;
      e_nrm <= d_nrm;
      f_nrm <= e_nrm;
      g_perp <= f_perp;
      g_nrm  <= f_nrm;
      // H: |1 - |perp|^2|, clamped to 32 bits
      mag     <= (absd > MAG_MAX) ? 32'hffffffff : absd[31:0];
      perp    <= g_perp;
      out_nrm <= g_nrm;
    end
  end

endmodule

// ===== rtl/rdu_sqrt.sv =====
module rdu_sqrt #(
  parameter int FRAC_BITS = 28,
  parameter int SIDE_W    = 192
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [31:0]                       mag,
  input  logic [SIDE_W-1:0]                 side,
  output logic                              out_valid,
  output logic [(32+FRAC_BITS+1)/2-1:0]     root,
  output logic [SIDE_W-1:0]                 out_side
);

  // one result bit per stage, from the top pair of mag * 2^FRAC_BITS down
  localparam int PAIRS = (32 + FRAC_BITS + 1) / 2;
  localparam int RW    = 2 * PAIRS;
  localparam int REM_W = PAIRS + 3;

  logic              v    [0:PAIRS];
  logic [RW-1:0]     rad  [0:PAIRS];
  logic [PAIRS-1:0]  rt   [0:PAIRS];
  logic [REM_W-1:0]  rem  [0:PAIRS];
  logic [SIDE_W-1:0] sd   [0:PAIRS];

  assign v[0]   = in_valid;
  assign rad[0] = RW'({mag, {FRAC_BITS{1'b0}}});
  assign rt[0]  = '0;
  assign rem[0] = '0;
  assign sd[0]  = side;

  for (genvar k = 0; k < PAIRS; k++) begin : g_step
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {rem[k][REM_W-3:0], rad[k][2*(PAIRS-1-k)+1 -: 2]};
    assign trial  = REM_W'({rt[k], 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1] <= rad[k];
        sd[k+1]  <= sd[k];
        if (rem_sh >= trial) begin
          rem[k+1] <= rem_sh - trial;
          rt[k+1]  <= {rt[k][PAIRS-2:0], 1'b1};
        end else begin
          rem[k+1] <= rem_sh;
          rt[k+1]  <= {rt[k][PAIRS-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[PAIRS];
  assign root      = rt[PAIRS];
  assign out_side  = sd[PAIRS];

endmodule

// ===== rtl/rdu_out.sv =====
module rdu_out import rdu_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [(32+FRAC_BITS+1)/2-1:0] root,
  input  vec_t                          perp,
  input  vec_t                          nrm,
  output logic                          out_valid,
  output vec_t                          result
);

  localparam int PAIRS = (32 + FRAC_BITS + 1) / 2;
  localparam int CW    = (PAIRS > 31) ? PAIRS : 31;

  logic [CW-1:0] root_ext;
  logic [30:0]   root_c;
  logic          p_valid;
  wide_t         p_prod [3];
  vec_t          p_perp;

  // clamp root to the signed range
  assign root_ext = CW'(root);
  assign root_c   = (root_ext > CW'(31'h7fffffff)) ? 31'h7fffffff : root_ext[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // P: parallel part, -root * n
        p_prod[i] <= -(wide_t'($signed({1'b0, root_c})) * wide_t'($signed(nrm[i])));
        // output register: perp + parallel
        result[i] <= sat32(wide_t'($signed(p_perp[i])) + rnd(p_prod[i], FRAC_BITS));
      end
      p_perp <= perp;
    end
  end

endmodule

// ===== rtl/refract_direction_unit_top.sv =====
// channel | dir | tdata fields, lowest bit up
// s_*     | in  | dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio, 1 pad bit
// m_*     | out | out_x, out_y, out_z
//
// One transaction per cycle unless the output stalls; the pipeline depth is
// set mostly by the square root, which resolves one result bit per stage.
// rst (synchronous) clears all valid bits; data registers are not reset.
// When m_tready is low with a result held, the whole pipeline freezes and
// s_tready drops; nothing is lost or repeated.
module refract_direction_unit_top import rdu_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [223:0] s_tdata,  // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata   // out_x, out_y, out_z
);

  localparam int PAIRS = (32 + FRAC_BITS + 1) / 2;

  logic              en;
  logic              dot_valid, perp_valid, sq_valid;
  q_t                cosine;
  vec_t              dot_dir, dot_nrm, perp_v, perp_nrm, sq_perp, sq_nrm, result;
  logic [30:0]       dot_eta;
  logic [31:0]       mag;
  logic [PAIRS-1:0]  root;
  logic [191:0]      sq_side;

  // global advance: move when the output register is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  rdu_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .dir(s_tdata[95:0]),
    .nrm(s_tdata[191:96]),
    .eta(s_tdata[222:192]),
    .out_valid(dot_valid), .cosine(cosine),
    .out_dir(dot_dir), .out_nrm(dot_nrm), .out_eta(dot_eta)
  );

  rdu_perp #(.FRAC_BITS(FRAC_BITS)) u_perp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(dot_valid), .cosine(cosine),
    .dir(dot_dir), .nrm(dot_nrm), .eta(dot_eta),
    .out_valid(perp_valid), .perp(perp_v), .out_nrm(perp_nrm), .mag(mag)
  );

  rdu_sqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_W(192)) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(perp_valid), .mag(mag),
    .side({perp_nrm, perp_v}),
    .out_valid(sq_valid), .root(root), .out_side(sq_side)
  );

  assign sq_perp = sq_side[95:0];
  assign sq_nrm  = sq_side[191:96];

  rdu_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sq_valid), .root(root),
    .perp(sq_perp), .nrm(sq_nrm),
    .out_valid(m_tvalid), .result(result)
  );

  assign m_tdata = result;

endmodule

// ===== rtl/rdu_checker.sv =====
module rdu_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [95:0]  m_tdata
);

  // a held result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");

  // a held result keeps its data
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed while stalled");

  // input side is open whenever the output register is empty
  a_ready_empty: assert property (@(posedge clk)
    !m_tvalid |-> s_tready) else $error("input blocked with empty output");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("result after reset");

endmodule

bind refract_direction_unit_top rdu_checker u_rdu_checker (
  .clk(clk), .rst(rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata)
);

// ===== tb/sv/refract_direction_unit_top_tb.sv =====
module refract_direction_unit_top_tb;
  import rdu_pkg::*;

  localparam int FB = 28;
  localparam int N_RANDOM = 1330;

  typedef struct packed {
    logic [30:0] eta;
    logic [31:0] nz, ny, nx, dz, dy, dx;
  } ray_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } dir3_t;

  // Snell refraction predictor plus queue of expected directions
  class refract_scoreboard;
    dir3_t pending[$];
    int errors;

    function longint round_q(longint p);
      return (p + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // floor(sqrt(mag * 2^FB)), bit by bit
    function longint isqrt_scaled(longint unsigned mag);
      logic [95:0] arg, rem, root, trial;
      arg = {32'b0, mag} << FB;
      rem = 0;
      root = 0;
      for (int k = 47; k >= 0; k--) begin
        rem = (rem << 2) | ((arg >> (2 * k)) & 96'd3);
        trial = (root << 2) | 96'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 96'd1;
        end else begin
          root = root << 1;
        end
      end
      return longint'(root[63:0]);
    endfunction

    function void note_ray(ray_t r);
      longint d[3], n[3], p[3], dot, cosine, len, diff, t, root;
      longint unsigned mag;
      longint one_q;
      longint o[3];
      dir3_t e;
      one_q = longint'(1) <<< FB;
      d[0] = longint'($signed(r.dx)); d[1] = longint'($signed(r.dy));
      d[2] = longint'($signed(r.dz));
      n[0] = longint'($signed(r.nx)); n[1] = longint'($signed(r.ny));
      n[2] = longint'($signed(r.nz));
      dot = 0;
      for (int i = 0; i < 3; i++) dot += round_q(-d[i] * n[i]);
      cosine = clamp32(dot < one_q ? dot : one_q);
      len = 0;
      for (int i = 0; i < 3; i++) begin
        t = clamp32(d[i] + round_q(cosine * n[i]));
        p[i] = clamp32(round_q(longint'(r.eta) * t));
        len += round_q(p[i] * p[i]);
      end
      diff = one_q - len;
      mag = diff < 0 ? -diff : diff;
      if (mag > 64'hffffffff) mag = 64'hffffffff;
      root = isqrt_scaled(mag);
      if (root > 64'sd2147483647) root = 64'sd2147483647;
      for (int i = 0; i < 3; i++) o[i] = clamp32(p[i] + round_q(root * -n[i]));
      e.x = o[0][31:0]; e.y = o[1][31:0]; e.z = o[2][31:0];
      pending.push_back(e);
    endfunction

    function void check_dir(logic [95:0] got);
      dir3_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got[31:0] !== e.x) begin
        $error("out_x expected %h actual %h", e.x, got[31:0]); errors++;
      end
      if (got[63:32] !== e.y) begin
        $error("out_y expected %h actual %h", e.y, got[63:32]); errors++;
      end
      if (got[95:64] !== e.z) begin
        $error("out_z expected %h actual %h", e.z, got[95:64]); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [223:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [95:0] m_tdata;

  refract_scoreboard sb = new();
  bit hold_off = 0;
  bit sending_done = 0;

  refract_direction_unit_top #(.FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 55) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] rand_comp();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_eta();
    if ($urandom_range(0, 9) == 0) return 31'($urandom());
    return 31'($urandom_range(32'h0800_0000, 32'h2000_0000));
  endfunction

  // offer one ray, optionally after an idle gap; called at a falling edge
  task automatic send_ray(ray_t r, int gap);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_ray(r);
    @(negedge clk);
  endtask

  function automatic ray_t make_ray(logic [31:0] dx, dy, dz, nx, ny, nz,
                                    logic [30:0] eta);
    ray_t r;
    r.dx = dx; r.dy = dy; r.dz = dz; r.nx = nx; r.ny = ny; r.nz = nz; r.eta = eta;
    return r;
  endfunction

  // stimulus
  initial begin
    ray_t r;
    localparam logic [31:0] ONE = 32'h1000_0000;
    localparam logic [31:0] MONE = 32'hf000_0000;
    localparam logic [30:0] ETA_ONE = 31'h1000_0000;
    repeat (2) @(negedge clk);
    rst <= 0;
    // directed: head-on, oblique, total internal reflection, extremes
    send_ray(make_ray(0, 0, MONE, 0, 0, ONE, ETA_ONE), 0);
    send_ray(make_ray(32'h0b50_4f33, 0, 32'hf4af_b0cd, 0, 0, ONE, 31'h0aaa_aaab), 0);
    send_ray(make_ray(32'h0e00_0000, 0, 32'hf800_0000, 0, 0, ONE, 31'h1800_0000), 0);
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 31'd0), 1);
    send_ray(make_ray('1, '1, '1, '1, '1, '1, '1), 0);
    send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff), 0);
    send_ray(make_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff), 0);
    send_ray(make_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'd0), 2);
    send_ray(make_ray(ONE, 0, 0, ONE, 0, 0, ETA_ONE), 0);
    send_ray(make_ray(MONE, 0, 0, MONE, 0, 0, ETA_ONE), 0);
    send_ray(make_ray(0, MONE, 0, 0, ONE, 0, 31'h7fff_ffff), 0);
    send_ray(make_ray(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                      32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 31'h5555_5555), 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      r = make_ray(rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_eta());
      // long back-to-back burst while the receiver holds off
      send_ray(r, (i >= 200 && i < 320) ? 0 : pick_gap());
    end
    s_tvalid <= 0;
    sending_done = 1;
  end

  // receiver: random stalls with one long hold-off
  initial begin
    int cnt;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        @(negedge clk);
      end else if ($urandom_range(0, 99) < 60) begin
        m_tready <= 1;
        @(negedge clk);
      end else begin
        cnt = pick_gap();
        m_tready <= 0;
        repeat (cnt + 1) @(negedge clk);
      end
    end
  end

  // long hold-off while the sender is still busy
  initial begin
    wait (!rst);
    repeat (500) @(posedge clk);
    hold_off = 1;
    repeat (200) @(posedge clk);
    hold_off = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_dir(m_tdata);
  end

  // completion
  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== refract_direction_unit_top.f =====
rtl/rdu_pkg.sv
rtl/rdu_dot.sv
rtl/rdu_perp.sv
rtl/rdu_sqrt.sv
rtl/rdu_out.sv
rtl/refract_direction_unit_top.sv
rtl/rdu_checker.sv
tb/sv/refract_direction_unit_top_tb.sv
